FILE: rtl/skf_pkg.sv
// skf_pkg: shared types and constants for the servo keyframe interpolator
// holds the item structs, command, status and register codes
// no dependencies
`default_nettype none

package skf_pkg;

    localparam int TIME_W     = 32;
    localparam int POS_W      = 10;
    localparam int MAX_JOINTS = 9;
    localparam int JIDX_W     = 4;
    localparam int DEN_W      = 32;
    localparam int PROD_W     = 42;
    localparam int CFG_IDX_W  = 3;
    localparam int SHIFT_W    = 3;

    // input commands
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_SHIFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEG_UPPER_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEG_UPPER_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEG_LOWER_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEG_LOWER_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_LOW       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_HIGH      = 3'd6;

    // joint that uses the body limit pair
    localparam logic [JIDX_W-1:0] BODY_JOINT = 4'd8;

    typedef struct packed {
        logic [1:0]        command;
        logic [TIME_W-1:0] time_ms;
        logic [POS_W-1:0]  pos_0;
        logic [POS_W-1:0]  pos_1;
        logic [POS_W-1:0]  pos_2;
        logic [POS_W-1:0]  pos_3;
        logic [POS_W-1:0]  pos_4;
        logic [POS_W-1:0]  pos_5;
        logic [POS_W-1:0]  pos_6;
        logic [POS_W-1:0]  pos_7;
        logic [POS_W-1:0]  pos_8;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [JIDX_W-1:0] joint_index;
        logic [POS_W-1:0]  target_position;
        logic              last;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/skf_key_store.sv
// skf_key_store: keyframe time memory and position row memory
// one write port and one registered read port on each; read data follows the address in the next cycle
// depends on skf_pkg
`default_nettype none

module skf_key_store #(
    parameter int MAX_KEYS     = 256,
    parameter int NUM_JOINTS_P = 9,
    parameter int IDX_W        = 8,
    parameter int ROW_W        = 90
) (
    input  wire                         clk,
    input  wire                         wr_en,
    input  wire  [IDX_W-1:0]            wr_addr,
    input  wire  [skf_pkg::TIME_W-1:0]  wr_time,
    input  wire  [ROW_W-1:0]            wr_row,
    input  wire  [IDX_W-1:0]            rd_addr,
    output logic [skf_pkg::TIME_W-1:0]  rd_time,
    output logic [ROW_W-1:0]            rd_row
);
    import skf_pkg::*;

    logic [TIME_W-1:0] time_mem [MAX_KEYS];
    logic [ROW_W-1:0]  row_mem  [MAX_KEYS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr] <= wr_time;
            row_mem[wr_addr]  <= wr_row;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_time <= time_mem[rd_addr];
        rd_row  <= row_mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/skf_divider.sv
// skf_divider: restoring unsigned divider, one quotient bit per cycle
// depends on skf_pkg
`default_nettype none

module skf_divider (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire  [skf_pkg::PROD_W-1:0]  num,
    input  wire  [skf_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [skf_pkg::PROD_W-1:0]  quo
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic             fits;

    // one shift and trial subtract per cycle
    always_comb
    begin
        shifted   = {rem_reg[DEN_W-1:0], quo_reg[PROD_W-1]};
        fits      = shifted >= {1'b0, den};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = CNT_W'(PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? shifted - {1'b0, den} : shifted;
            quo_next = {quo_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/servo_keyframe_interpolator.sv
// servo_keyframe_interpolator: keyframe table with linear interpolation per joint
// append, clear and status items: one result via ST_EMIT, then back to ST_IDLE
// query: search (k keys passed, one key per cycle), row fetch in ST_RD0 and ST_RD1, then
// per joint ST_MUL, the 42-step divider in ST_DIV (skipped if both keys share a time),
// ST_FIN and ST_EMIT, where each of nine results waits out any output stall
// reset empties the table and loads the default limits; memories are not cleared
`default_nettype none

module servo_keyframe_interpolator #(
    parameter int MAX_KEYS     = 256,
    parameter int NUM_JOINTS_P = 9
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  skf_pkg::in_item_t           in_data,
    output logic                              out_valid,
    input  wire                               out_ready,
    output skf_pkg::out_item_t                out_data,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [skf_pkg::POS_W-1:0]         cfg_data
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int ROW_W = NUM_JOINTS_P * POS_W;
    localparam int VAL_W = PROD_W + 2;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEARCH = 8'b0000_0010,
        ST_RD0    = 8'b0000_0100,
        ST_RD1    = 8'b0000_1000,
        ST_MUL    = 8'b0001_0000,
        ST_DIV    = 8'b0010_0000,
        ST_FIN    = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [SHIFT_W-1:0] shift_reg;
    logic [POS_W-1:0]   uplo_reg, uphi_reg, lolo_reg, lohi_reg, bdlo_reg, bdhi_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  i1_reg, i1_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [TIME_W-1:0] time0_reg, time0_next;
    logic [ROW_W-1:0]  arow_reg, arow_next, brow_reg, brow_next;
    logic [DEN_W-1:0]  dmag_reg, dmag_next;
    logic              dneg_reg, dneg_next, dzero_reg, dzero_next;
    logic [TIME_W-1:0] delta_reg, delta_next;
    logic [JIDX_W-1:0] j_reg, j_next;
    logic              neg_reg, neg_next;
    out_item_t         res_reg, res_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // memory side
    logic              wr_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] rd_time;
    logic [ROW_W-1:0]  rd_row, wr_row;
    logic [POS_W-1:0]  pos_arr [MAX_JOINTS];

    // divider side
    logic              div_start, div_done;
    logic [PROD_W-1:0] div_quo;

    // datapath helpers
    logic              in_acc, slot_free, advance;
    logic [CNT_W-1:0]  i0_cur, i1_fin;
    logic [TIME_W:0]   dist_s;
    logic [POS_W-1:0]  a_pos, b_pos;
    logic [POS_W:0]    diff_s;
    logic [POS_W-1:0]  diff_mag;
    logic [PROD_W-1:0] prod_val;
    logic [VAL_W-1:0]  a_ext, v_raw, v_lo, v_clamped;
    logic [POS_W-1:0]  lim_lo, lim_hi;

    assign in_acc    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || out_ready;

    // input positions as a row of the active joints
    assign pos_arr[0] = in_data.pos_0;
    assign pos_arr[1] = in_data.pos_1;
    assign pos_arr[2] = in_data.pos_2;
    assign pos_arr[3] = in_data.pos_3;
    assign pos_arr[4] = in_data.pos_4;
    assign pos_arr[5] = in_data.pos_5;
    assign pos_arr[6] = in_data.pos_6;
    assign pos_arr[7] = in_data.pos_7;
    assign pos_arr[8] = in_data.pos_8;

    for (genvar k = 0; k < NUM_JOINTS_P; k++)
    begin : g_row
        assign wr_row[k*POS_W +: POS_W] = pos_arr[k];
    end

    assign wr_en = in_acc && (in_data.command == CMD_APPEND)
                   && (count_reg < CNT_W'(MAX_KEYS));

    skf_key_store #(
        .MAX_KEYS     (MAX_KEYS),
        .NUM_JOINTS_P (NUM_JOINTS_P),
        .IDX_W        (IDX_W),
        .ROW_W        (ROW_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_time (in_data.time_ms),
        .wr_row  (wr_row),
        .rd_addr (rd_addr),
        .rd_time (rd_time),
        .rd_row  (rd_row)
    );

    skf_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_val),
        .den   (dmag_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // search and segment selection
    assign advance = (i1_reg < count_reg) && (t_reg > rd_time);
    assign i0_cur  = i1_reg - 1'b1;
    assign i1_fin  = (i1_reg >= count_reg) ? i0_cur : i1_reg;
    assign dist_s  = {1'b0, rd_time} - {1'b0, time0_reg};

    // joint operands
    assign a_pos    = arow_reg[j_reg*POS_W +: POS_W];
    assign b_pos    = brow_reg[j_reg*POS_W +: POS_W];
    assign diff_s   = {1'b0, b_pos} - {1'b0, a_pos};
    assign diff_mag = diff_s[POS_W] ? POS_W'(-diff_s) : diff_s[POS_W-1:0];
    assign prod_val = PROD_W'(diff_mag) * PROD_W'(delta_reg);

    // limit pair of the current joint
    always_comb
    begin
        if (j_reg == BODY_JOINT)
        begin
            lim_lo = bdlo_reg;
            lim_hi = bdhi_reg;
        end
        else if (!j_reg[0])
        begin
            lim_lo = uplo_reg;
            lim_hi = uphi_reg;
        end
        else
        begin
            lim_lo = lolo_reg;
            lim_hi = lohi_reg;
        end
    end

    // interpolated value and clamp
    always_comb
    begin
        a_ext = VAL_W'(a_pos);
        if (dzero_reg)
            v_raw = a_ext;
        else if (neg_reg)
            v_raw = a_ext - VAL_W'(div_quo);
        else
            v_raw = a_ext + VAL_W'(div_quo);
        v_lo      = ($signed(v_raw) < $signed(VAL_W'(lim_lo))) ? VAL_W'(lim_lo) : v_raw;
        v_clamped = ($signed(v_lo) > $signed(VAL_W'(lim_hi))) ? VAL_W'(lim_hi) : v_lo;
    end

    // control sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        i1_next        = i1_reg;
        t_next         = t_reg;
        time0_next     = time0_reg;
        arow_next      = arow_reg;
        brow_next      = brow_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        dzero_next     = dzero_reg;
        delta_next     = delta_reg;
        j_next         = j_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_addr        = i1_reg[IDX_W-1:0];
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = IDX_W'(1);
                i1_next = CNT_W'(1);
                t_next  = in_data.time_ms >> shift_reg;
                res_next.status          = STAT_OK;
                res_next.joint_index     = '0;
                res_next.target_position = '0;
                res_next.last            = 1'b1;
                if (in_acc)
                begin
                    case (in_data.command)
                        CMD_APPEND:
                        begin
                            state_next = ST_EMIT;
                            if (count_reg < CNT_W'(MAX_KEYS))
                                count_next = count_reg + 1'b1;
                            else
                                res_next.status = STAT_FULL;
                        end
                        CMD_CLEAR:
                        begin
                            state_next = ST_EMIT;
                            count_next = '0;
                        end
                        CMD_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next      = ST_EMIT;
                                res_next.status = STAT_EMPTY;
                            end
                            else
                                state_next = ST_SEARCH;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (advance)
                begin
                    i1_next = i1_reg + 1'b1;
                    rd_addr = i1_next[IDX_W-1:0];
                end
                else
                begin
                    rd_addr    = i0_cur[IDX_W-1:0];
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                time0_next = rd_time;
                arow_next  = rd_row;
                rd_addr    = i1_fin[IDX_W-1:0];
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                brow_next  = rd_row;
                dneg_next  = dist_s[TIME_W];
                dmag_next  = dist_s[TIME_W] ? DEN_W'(-dist_s) : dist_s[DEN_W-1:0];
                dzero_next = (dist_s == '0);
                delta_next = (t_reg > time0_reg) ? t_reg - time0_reg : '0;
                j_next     = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                neg_next  = diff_s[POS_W] ^ dneg_reg;
                if (dzero_reg)
                    state_next = ST_FIN;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                res_next.status          = STAT_OK;
                res_next.joint_index     = j_reg;
                res_next.target_position = v_clamped[POS_W-1:0];
                res_next.last            = (j_reg == JIDX_W'(NUM_JOINTS_P - 1));
                state_next               = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    if (res_reg.last)
                        state_next = ST_IDLE;
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        i1_reg    <= i1_next;
        t_reg     <= t_next;
        time0_reg <= time0_next;
        arow_reg  <= arow_next;
        brow_reg  <= brow_next;
        dmag_reg  <= dmag_next;
        dneg_reg  <= dneg_next;
        dzero_reg <= dzero_next;
        delta_reg <= delta_next;
        j_reg     <= j_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_W'(2);
            uplo_reg  <= POS_W'(150);
            uphi_reg  <= POS_W'(770);
            lolo_reg  <= POS_W'(30);
            lohi_reg  <= POS_W'(940);
            bdlo_reg  <= POS_W'(332);
            bdhi_reg  <= POS_W'(692);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TIME_SHIFT:     shift_reg <= cfg_data[SHIFT_W-1:0];
                REG_LEG_UPPER_LOW:  uplo_reg  <= cfg_data;
                REG_LEG_UPPER_HIGH: uphi_reg  <= cfg_data;
                REG_LEG_LOWER_LOW:  lolo_reg  <= cfg_data;
                REG_LEG_LOWER_HIGH: lohi_reg  <= cfg_data;
                REG_BODY_LOW:       bdlo_reg  <= cfg_data;
                REG_BODY_HIGH:      bdhi_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // table fill never passes capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_KEYS))
        else $error("key count beyond capacity");

    // search never walks past the stored keys
    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (i1_reg <= count_reg) && (count_reg != '0))
        else $error("search index out of table");

    // divider finishes only while a joint waits on it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide step");

    // a result is loaded only into a free output register
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid_reg && !out_ready) |=> $stable(out_reg))
        else $error("output item overwritten");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// tb_top: self-checking bench for the servo keyframe interpolator
// drives keyframe loads, clears, queries and register writes against an internal predictor
// depends on rtl/skf_pkg.sv and rtl/servo_keyframe_interpolator.sv
`timescale 1ns / 100ps

module tb_top;
    import skf_pkg::*;

    localparam int N_KEYS   = 256;
    localparam int N_JOINTS = 9;
    localparam int QUIET_CYCLES = 600;

    // command code the block ignores
    localparam logic [1:0] CMD_RSVD = 2'd3;

    typedef struct {
        in_item_t data;
        int       gap;
    } pending_item_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [POS_W-1:0] cfg_data;

    servo_keyframe_interpolator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [TIME_W-1:0] key_time_tbl [N_KEYS];
    logic [POS_W-1:0]  key_pos_tbl  [N_KEYS][N_JOINTS];
    int                key_total;
    logic [SHIFT_W-1:0] shift_q;
    logic [POS_W-1:0]  lim_lo [3];   // 0 even legs, 1 odd legs, 2 body
    logic [POS_W-1:0]  lim_hi [3];

    out_item_t     expected_targets [$];
    pending_item_t pending_items [$];

    int  mismatches;
    bit  fast_mode;
    int  hold_requests;
    int  hold_served;
    bit  in_took;
    bit  out_took;
    int  tx_wait;
    bit  tx_gap_loaded;
    int  rx_wait;
    int  rx_hold;

    // stimulus-side shadow of the table for well-formed sequences
    int                gen_keys;
    logic [TIME_W-1:0] gen_last_time;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #36_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [POS_W-1:0] clamp_target(int j, longint v);
        int grp;
        grp = (j == int'(BODY_JOINT)) ? 2 : ((j % 2 == 0) ? 0 : 1);
        if (v < longint'(lim_lo[grp]))
            v = longint'(lim_lo[grp]);
        if (v > longint'(lim_hi[grp]))
            v = longint'(lim_hi[grp]);
        return v[POS_W-1:0];
    endfunction

    function automatic out_item_t status_item(logic [1:0] st);
        out_item_t r;
        r.status = st;
        r.joint_index = '0;
        r.target_position = '0;
        r.last = 1'b1;
        return r;
    endfunction

    // work out the results caused by one accepted item
    task automatic predict_servo_targets(in_item_t it);
        logic [TIME_W-1:0] t;
        int i0, i1;
        longint span_len, delta, a, b, v;
        out_item_t r;
        logic [POS_W-1:0] p [N_JOINTS];
        p = '{it.pos_0, it.pos_1, it.pos_2, it.pos_3, it.pos_4,
              it.pos_5, it.pos_6, it.pos_7, it.pos_8};
        case (it.command)
            CMD_APPEND:
            begin
                if (key_total >= N_KEYS)
                    expected_targets.insert(expected_targets.size(),
                                            status_item(STAT_FULL));
                else
                begin
                    key_time_tbl[key_total] = it.time_ms;
                    for (int j = 0; j < N_JOINTS; j++)
                        key_pos_tbl[key_total][j] = p[j];
                    key_total++;
                    expected_targets.insert(expected_targets.size(),
                                            status_item(STAT_OK));
                end
            end
            CMD_CLEAR:
            begin
                key_total = 0;
                expected_targets.insert(expected_targets.size(), status_item(STAT_OK));
            end
            CMD_QUERY:
            begin
                if (key_total == 0)
                    expected_targets.insert(expected_targets.size(),
                                            status_item(STAT_EMPTY));
                else
                begin
                    t = it.time_ms >> shift_q;
                    i0 = 0;
                    i1 = 1;
                    while (i1 < key_total && t > key_time_tbl[i1])
                    begin
                        i0 = i1;
                        i1++;
                    end
                    if (i1 >= key_total)
                        i1 = i0;
                    span_len = longint'({32'b0, key_time_tbl[i1]})
                             - longint'({32'b0, key_time_tbl[i0]});
                    delta = longint'({32'b0, t}) - longint'({32'b0, key_time_tbl[i0]});
                    if (delta < 0)
                        delta = 0;
                    for (int j = 0; j < N_JOINTS; j++)
                    begin
                        a = longint'(key_pos_tbl[i0][j]);
                        b = longint'(key_pos_tbl[i1][j]);
                        v = a;
                        if (span_len != 0)
                            v = a + ((b - a) * delta) / span_len;
                        r.status = STAT_OK;
                        r.joint_index = j[JIDX_W-1:0];
                        r.target_position = clamp_target(j, v);
                        r.last = (j == N_JOINTS - 1);
                        expected_targets.insert(expected_targets.size(), r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // monitor: accepts on both channels, result checking
    always @(posedge clk)
    begin
        in_took <= in_valid && in_ready;
        out_took <= out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
            predict_servo_targets(in_data);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_targets.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_data);
            end
            else
            begin
                if (out_data !== expected_targets[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p",
                                 expected_targets[0], out_data);
                end
                void'(expected_targets.pop_front());
            end
        end
    end

    // driver: feeds pending items with their gaps
    always @(negedge clk)
    begin
        logic v;
        v = in_valid;
        if (in_valid && in_took)
            v = 1'b0;
        if (!v && rst_n && pending_items.size() > 0)
        begin
            if (!tx_gap_loaded)
            begin
                tx_wait = pending_items[0].gap;
                tx_gap_loaded = 1'b1;
            end
            if (tx_wait > 0)
                tx_wait--;
            else
            begin
                in_data <= pending_items[0].data;
                void'(pending_items.pop_front());
                tx_gap_loaded = 1'b0;
                v = 1'b1;
            end
        end
        in_valid <= v;
    end

    // receiver: random stalls plus the long hold-off on request
    always @(negedge clk)
    begin
        logic r;
        if (out_took)
            rx_wait = fast_mode ? 0 : $urandom_range(0, 14);
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            rx_hold = 3000;
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            r = 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            r = 1'b0;
        end
        else
            r = 1'b1;
        out_ready <= r;
    end

    task automatic push_item(logic [1:0] cmd, logic [TIME_W-1:0] t, bit rand_pos,
                             logic [POS_W-1:0] fill);
        pending_item_t pi;
        pi.data.command = cmd;
        pi.data.time_ms = t;
        pi.data.pos_0 = rand_pos ? POS_W'($urandom) : fill;
        pi.data.pos_1 = rand_pos ? POS_W'($urandom) : fill;
        pi.data.pos_2 = rand_pos ? POS_W'($urandom) : fill;
        pi.data.pos_3 = rand_pos ? POS_W'($urandom) : fill;
        pi.data.pos_4 = rand_pos ? POS_W'($urandom) : fill;
        pi.data.pos_5 = rand_pos ? POS_W'($urandom) : fill;
        pi.data.pos_6 = rand_pos ? POS_W'($urandom) : fill;
        pi.data.pos_7 = rand_pos ? POS_W'($urandom) : fill;
        pi.data.pos_8 = rand_pos ? POS_W'($urandom) : fill;
        pi.gap = fast_mode ? 0 : $urandom_range(0, 14);
        pending_items.insert(pending_items.size(), pi);
    endtask

    // block drained, then let any resultless item finish
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_targets.size() != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_TIME_SHIFT:     shift_q = val[SHIFT_W-1:0];
            REG_LEG_UPPER_LOW:  lim_lo[0] = val;
            REG_LEG_UPPER_HIGH: lim_hi[0] = val;
            REG_LEG_LOWER_LOW:  lim_lo[1] = val;
            REG_LEG_LOWER_HIGH: lim_hi[1] = val;
            REG_BODY_LOW:       lim_lo[2] = val;
            REG_BODY_HIGH:      lim_hi[2] = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(logic [POS_W-1:0] sh, logic [POS_W-1:0] ul,
                                  logic [POS_W-1:0] uh, logic [POS_W-1:0] ll,
                                  logic [POS_W-1:0] lh, logic [POS_W-1:0] bl,
                                  logic [POS_W-1:0] bh);
        wait_quiet();
        write_reg(REG_TIME_SHIFT, sh);
        write_reg(REG_LEG_UPPER_LOW, ul);
        write_reg(REG_LEG_UPPER_HIGH, uh);
        write_reg(REG_LEG_LOWER_LOW, ll);
        write_reg(REG_LEG_LOWER_HIGH, lh);
        write_reg(REG_BODY_LOW, bl);
        write_reg(REG_BODY_HIGH, bh);
    endtask

    // mostly well-formed tables of ascending keys with queries spread over them
    task automatic random_items(int n);
        int r, cnt;
        logic [TIME_W-1:0] t, span;
        cnt = 0;
        while (cnt < n)
        begin
            r = $urandom_range(0, 99);
            if (r % 10 == 0)
                fast_mode = ~fast_mode;
            if (r < 35)
            begin
                if (gen_keys >= 40)
                begin
                    push_item(CMD_CLEAR, $urandom, 1'b1, '0);
                    gen_keys = 0;
                    gen_last_time = '0;
                end
                else
                begin
                    if ($urandom_range(0, 19) == 0)
                        t = $urandom;
                    else
                        t = gen_last_time + $urandom_range(0, 300);
                    push_item(CMD_APPEND, t, 1'b1, '0);
                    gen_keys++;
                    gen_last_time = t;
                end
            end
            else if (r < 87)
            begin
                span = gen_last_time + 200;
                if ($urandom_range(0, 9) == 0)
                    t = $urandom;
                else
                    t = (TIME_W'($urandom_range(0, span)) << shift_q)
                        | (TIME_W'($urandom) & ((TIME_W'(1) << shift_q) - 1));
                push_item(CMD_QUERY, t, 1'b1, '0);
            end
            else if (r < 92)
            begin
                push_item(CMD_CLEAR, $urandom, 1'b1, '0);
                gen_keys = 0;
                gen_last_time = '0;
            end
            else if (r < 95)
            begin
                // unused command, ignored by the block
                push_item(CMD_RSVD, $urandom, 1'b1, '0);
                cnt--;
            end
            else
            begin
                push_item(CMD_QUERY, 32'hFFFF_FFFF, 1'b1, '0);
            end
            cnt++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        fast_mode = 1'b0;
        hold_requests = 0;
        hold_served = 0;
        in_took = 1'b0;
        out_took = 1'b0;
        tx_wait = 0;
        tx_gap_loaded = 1'b0;
        rx_wait = 0;
        rx_hold = 0;
        gen_keys = 0;
        gen_last_time = '0;
        key_total = 0;
        shift_q = 3'd2;
        lim_lo = '{10'd150, 10'd30, 10'd332};
        lim_hi = '{10'd770, 10'd940, 10'd692};
        foreach (key_time_tbl[i])
            key_time_tbl[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, ignored command, extremes, equal times
        push_item(CMD_QUERY, 32'd0, 1'b0, '0);
        push_item(CMD_RSVD, 32'hFFFF_FFFF, 1'b0, 10'h3FF);
        push_item(CMD_APPEND, 32'd0, 1'b0, 10'd0);
        push_item(CMD_QUERY, 32'd0, 1'b0, '0);
        push_item(CMD_APPEND, 32'd100, 1'b0, 10'h3FF);
        push_item(CMD_QUERY, 32'd200, 1'b0, '0);
        push_item(CMD_QUERY, 32'd399, 1'b0, '0);
        push_item(CMD_QUERY, 32'hFFFF_FFFF, 1'b0, '0);
        push_item(CMD_APPEND, 32'd100, 1'b0, 10'd500);
        push_item(CMD_QUERY, 32'd400, 1'b0, '0);
        push_item(CMD_CLEAR, 32'hFFFF_FFFF, 1'b0, 10'h3FF);
        push_item(CMD_QUERY, 32'd40, 1'b0, '0);
        push_item(CMD_APPEND, 32'd50, 1'b0, 10'd900);
        push_item(CMD_APPEND, 32'd90, 1'b0, 10'd10);
        push_item(CMD_QUERY, 32'd0, 1'b0, '0);
        push_item(CMD_QUERY, 32'd290, 1'b0, '0);
        // key out of order
        push_item(CMD_APPEND, 32'd20, 1'b1, '0);
        push_item(CMD_QUERY, 32'd370, 1'b0, '0);
        push_item(CMD_QUERY, 32'd1000, 1'b0, '0);
        push_item(CMD_CLEAR, 32'd0, 1'b0, '0);
        random_items(3);

        // widest limits, no scaling
        write_all_regs(10'd0, 10'd0, 10'h3FF, 10'd0, 10'h3FF, 10'd0, 10'h3FF);
        push_item(CMD_CLEAR, 32'd0, 1'b0, '0);
        gen_keys = 0;
        gen_last_time = '0;
        random_items(3);

        // largest shift, inverted and pinched limits
        write_all_regs(10'd7, 10'h3FF, 10'd0, 10'd512, 10'd511, 10'd700, 10'd700);
        random_items(3);

        // random settings
        write_all_regs(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                       10'($urandom), 10'($urandom), 10'($urandom));
        random_items(3);
        write_all_regs(10'($urandom_range(0, 7)), 10'($urandom_range(0, 400)),
                       10'($urandom_range(500, 1023)), 10'($urandom_range(0, 400)),
                       10'($urandom_range(500, 1023)), 10'($urandom_range(0, 400)),
                       10'($urandom_range(500, 1023)));
        random_items(3);

        // full table under a long output stall, then overflow and queries
        write_all_regs(10'd2, 10'd150, 10'd770, 10'd30, 10'd940, 10'd332, 10'd692);
        fast_mode = 1'b1;
        hold_requests++;
        push_item(CMD_CLEAR, 32'd0, 1'b0, '0);
        push_item(CMD_QUERY, 32'd5, 1'b1, '0);
        for (int k = 0; k < N_KEYS; k++)
            push_item(CMD_APPEND, 32'(k * 37 + $urandom_range(0, 36)), 1'b1, '0);
        push_item(CMD_APPEND, 32'hFFFF_FFFF, 1'b1, '0);
        fast_mode = 1'b0;
        push_item(CMD_QUERY, 32'd0, 1'b0, '0);
        push_item(CMD_QUERY, 32'(($urandom_range(0, 9500)) << 2), 1'b0, '0);
        push_item(CMD_QUERY, 32'hFFFF_FFFF, 1'b0, '0);
        push_item(CMD_CLEAR, 32'd0, 1'b0, '0);
        gen_keys = 0;
        gen_last_time = '0;
        random_items(3);

        // drain and finish
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_targets.size() != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_targets.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
